>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent checks, synchronous active-low reset disables them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wts check failed");

// next-cycle implication
`define WTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wts check failed");

`endif

>>> hw/rtl/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// widths, register indexes, config type and small arithmetic helpers
// ----------------------------------------------------------------------------
package wts_pkg;

  localparam int unsigned NSENS      = 3;
  localparam int unsigned TIME_W     = 40;
  localparam int unsigned IVL_W      = 16;
  localparam int unsigned IVL_SEC_W  = 22;
  localparam int unsigned DEADLINE_W = 41;
  localparam int unsigned REM_W      = 42;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned MOD_W      = 11;
  localparam int unsigned WIN_W      = 11;
  localparam int unsigned WIN_END_W  = 12;
  localparam int unsigned MDIFF_W    = 13;
  localparam int unsigned MWAIT_W    = 12;
  localparam int unsigned SLEEP_W    = 17;
  localparam int unsigned WAIT_W     = 18;
  localparam int unsigned YEAR_W     = 12;
  localparam int unsigned DAY_W      = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DEF_MAX_SLEEP_SECONDS = 3600;
  localparam int unsigned DEF_MIN_WAKE_SECONDS  = 60;

  localparam logic signed [MDIFF_W-1:0] MINUTES_PER_DAY = 13'sd1440;
  localparam logic [WAIT_W-1:0]         PHOTO_WAIT_CAP  = 18'd172800;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHOTO_HOUR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHOTO_MINUTE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PHOTO_WINDOW = 3'd6;

  typedef struct packed {
    logic [NSENS-1:0]            enable_mask;
    logic [NSENS-1:0][IVL_W-1:0] interval_minutes;
    logic [HOUR_W-1:0]           photo_hour;
    logic [MINUTE_W-1:0]         photo_minute;
    logic [WIN_W-1:0]            photo_window_minutes;
  } wts_cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } wts_adv_t;

  function automatic logic [MOD_W-1:0] minute_of_day(input logic [HOUR_W-1:0] hour,
                                                     input logic [MINUTE_W-1:0] minute);
    logic [MOD_W-1:0] h;
    h = {{(MOD_W-HOUR_W){1'b0}}, hour};
    return (h << 6) - (h << 2) + {{(MOD_W-MINUTE_W){1'b0}}, minute};
  endfunction

  function automatic logic [WAIT_W-1:0] minutes_to_seconds(input logic [MWAIT_W-1:0] m);
    logic [WAIT_W-1:0] w;
    w = {{(WAIT_W-MWAIT_W){1'b0}}, m};
    return (w << 6) - (w << 2);
  endfunction

endpackage

>>> hw/rtl/wts_if.sv
// ----------------------------------------------------------------------------
// wts channel interfaces
// request, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface wts_in_if;
  logic                              valid;
  logic                              ready;
  logic [wts_pkg::TIME_W-1:0]        now_seconds;
  logic [wts_pkg::TIME_W-1:0]        last_read_0;
  logic [wts_pkg::TIME_W-1:0]        last_read_1;
  logic [wts_pkg::TIME_W-1:0]        last_read_2;
  logic                              clock_trusted;
  logic [wts_pkg::HOUR_W-1:0]        local_hour;
  logic [wts_pkg::MINUTE_W-1:0]      local_minute;
  logic [wts_pkg::YEAR_W-1:0]        local_year;
  logic [wts_pkg::DAY_W-1:0]         local_day_of_year;
  logic [wts_pkg::YEAR_W-1:0]        photo_year;
  logic [wts_pkg::DAY_W-1:0]         photo_day;

  modport source (
    output valid, now_seconds, last_read_0, last_read_1, last_read_2, clock_trusted,
           local_hour, local_minute, local_year, local_day_of_year, photo_year, photo_day,
    input  ready
  );
  modport sink (
    input  valid, now_seconds, last_read_0, last_read_1, last_read_2, clock_trusted,
           local_hour, local_minute, local_year, local_day_of_year, photo_year, photo_day,
    output ready
  );
endinterface

interface wts_out_if;
  logic                         valid;
  logic                         ready;
  logic                         due_sensor_0;
  logic                         due_sensor_1;
  logic                         due_sensor_2;
  logic                         photo_due;
  logic [wts_pkg::SLEEP_W-1:0]  sleep_seconds;
  logic [wts_pkg::WAIT_W-1:0]   photo_wait_seconds;
  logic                         photo_wait_unknown;

  modport source (
    output valid, due_sensor_0, due_sensor_1, due_sensor_2, photo_due, sleep_seconds,
           photo_wait_seconds, photo_wait_unknown,
    input  ready
  );
  modport sink (
    input  valid, due_sensor_0, due_sensor_1, due_sensor_2, photo_due, sleep_seconds,
           photo_wait_seconds, photo_wait_unknown,
    output ready
  );
endinterface

interface wts_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wts_pkg::CFG_IDX_W-1:0]   index;
  logic [wts_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/wts_cfg_regs.sv
// ----------------------------------------------------------------------------
// wts_cfg_regs
// schedule register file, written one word at a time
// ----------------------------------------------------------------------------
module wts_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  wts_cfg_if.sink           cfg_ch,
  output wts_pkg::wts_cfg_t cfg
);

  wts_pkg::wts_cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask          <= 3'd7;
      cfg_r.interval_minutes[0]  <= 16'd15;
      cfg_r.interval_minutes[1]  <= 16'd15;
      cfg_r.interval_minutes[2]  <= 16'd15;
      cfg_r.photo_hour           <= 5'd12;
      cfg_r.photo_minute         <= 6'd0;
      cfg_r.photo_window_minutes <= 11'd30;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        wts_pkg::REG_ENABLE_MASK: begin
          cfg_r.enable_mask <= cfg_ch.data[wts_pkg::NSENS-1:0];
        end
        wts_pkg::REG_INTERVAL_0: begin
          cfg_r.interval_minutes[0] <= cfg_ch.data[wts_pkg::IVL_W-1:0];
        end
        wts_pkg::REG_INTERVAL_1: begin
          cfg_r.interval_minutes[1] <= cfg_ch.data[wts_pkg::IVL_W-1:0];
        end
        wts_pkg::REG_INTERVAL_2: begin
          cfg_r.interval_minutes[2] <= cfg_ch.data[wts_pkg::IVL_W-1:0];
        end
        wts_pkg::REG_PHOTO_HOUR: begin
          cfg_r.photo_hour <= cfg_ch.data[wts_pkg::HOUR_W-1:0];
        end
        wts_pkg::REG_PHOTO_MINUTE: begin
          cfg_r.photo_minute <= cfg_ch.data[wts_pkg::MINUTE_W-1:0];
        end
        wts_pkg::REG_PHOTO_WINDOW: begin
          cfg_r.photo_window_minutes <= cfg_ch.data[wts_pkg::WIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/wts_sensor_lane.sv
// ----------------------------------------------------------------------------
// wts_sensor_lane
// one sensor: due flag and remaining seconds, three register stages
// ----------------------------------------------------------------------------
module wts_sensor_lane #(
  parameter int unsigned MAX_SLEEP_SECONDS = wts_pkg::DEF_MAX_SLEEP_SECONDS
) (
  input  logic                         clk,
  input  wts_pkg::wts_adv_t            adv,
  input  logic [wts_pkg::TIME_W-1:0]   now_seconds,
  input  logic [wts_pkg::TIME_W-1:0]   last_read,
  input  logic                         enable,
  input  logic [wts_pkg::IVL_W-1:0]    interval_minutes,
  output logic                         due,
  output logic [wts_pkg::SLEEP_W-1:0]  remaining
);

  localparam logic [wts_pkg::SLEEP_W-1:0] MAX_SLEEP = wts_pkg::SLEEP_W'(MAX_SLEEP_SECONDS);
  localparam logic [wts_pkg::REM_W-1:0]   MAX_REM   = wts_pkg::REM_W'(MAX_SLEEP_SECONDS);

  logic                              en1_r, en2_r;
  logic                              never1_r, never2_r;
  logic [wts_pkg::TIME_W-1:0]        now1_r, now2_r;
  logic [wts_pkg::TIME_W-1:0]        last1_r;
  logic [wts_pkg::IVL_SEC_W-1:0]     ivl_sec1_r;
  logic [wts_pkg::DEADLINE_W-1:0]    deadline2_r;
  logic                              due3_r;
  logic [wts_pkg::SLEEP_W-1:0]       rem3_r;

  logic [wts_pkg::IVL_SEC_W-1:0]     ivl_ext;
  logic [wts_pkg::DEADLINE_W-1:0]    deadline_nxt;
  logic [wts_pkg::REM_W-1:0]         diff;
  logic                              expired;
  logic                              due_nxt;
  logic [wts_pkg::SLEEP_W-1:0]       rem_nxt;

  // interval in minutes, widened to the seconds width
  assign ivl_ext = {{(wts_pkg::IVL_SEC_W-wts_pkg::IVL_W){1'b0}}, interval_minutes};

  assign deadline_nxt = {1'b0, last1_r} +
                        {{(wts_pkg::DEADLINE_W-wts_pkg::IVL_SEC_W){1'b0}}, ivl_sec1_r};

  always_comb begin
    diff    = {1'b0, deadline2_r} - {2'b0, now2_r};
    expired = never2_r | diff[wts_pkg::REM_W-1] | (diff == '0);
    due_nxt = en2_r & expired;
    if (!en2_r) begin
      rem_nxt = MAX_SLEEP;
    end else if (expired) begin
      rem_nxt = '0;
    end else if (diff > MAX_REM) begin
      rem_nxt = MAX_SLEEP;
    end else begin
      rem_nxt = diff[wts_pkg::SLEEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      en1_r      <= enable;
      never1_r   <= (last_read == '0);
      now1_r     <= now_seconds;
      last1_r    <= last_read;
      ivl_sec1_r <= (ivl_ext << 6) - (ivl_ext << 2);
    end
    if (adv.s2) begin
      en2_r       <= en1_r;
      never2_r    <= never1_r;
      now2_r      <= now1_r;
      deadline2_r <= deadline_nxt;
    end
    if (adv.s3) begin
      due3_r <= due_nxt;
      rem3_r <= rem_nxt;
    end
  end

  assign due       = due3_r;
  assign remaining = rem3_r;

endmodule

>>> hw/rtl/wts_photo_calc.sv
// ----------------------------------------------------------------------------
// wts_photo_calc
// daily photo window check, sleep term and photo wait, three register stages
// ----------------------------------------------------------------------------
module wts_photo_calc (
  input  logic                          clk,
  input  wts_pkg::wts_adv_t             adv,
  input  wts_pkg::wts_cfg_t             cfg,
  input  logic                          clock_trusted,
  input  logic [wts_pkg::HOUR_W-1:0]    local_hour,
  input  logic [wts_pkg::MINUTE_W-1:0]  local_minute,
  input  logic [wts_pkg::YEAR_W-1:0]    local_year,
  input  logic [wts_pkg::DAY_W-1:0]     local_day_of_year,
  input  logic [wts_pkg::YEAR_W-1:0]    photo_year,
  input  logic [wts_pkg::DAY_W-1:0]     photo_day,
  output logic                          trusted,
  output logic                          photo_due,
  output logic [wts_pkg::SLEEP_W-1:0]   photo_term,
  output logic [wts_pkg::WAIT_W-1:0]    photo_wait
);

  logic                              trusted1_r, trusted2_r, trusted3_r;
  logic                              taken1_r;
  logic [wts_pkg::MOD_W-1:0]         cur1_r, target1_r;
  logic [wts_pkg::WIN_END_W-1:0]     win_end1_r;
  logic                              due2_r, due3_r;
  logic [wts_pkg::MWAIT_W-1:0]       m_term2_r, m_wait2_r;
  logic [wts_pkg::SLEEP_W-1:0]       term3_r;
  logic [wts_pkg::WAIT_W-1:0]        wait3_r;

  logic [wts_pkg::MOD_W-1:0]         target_nxt;
  logic signed [wts_pkg::MDIFF_W-1:0] diff, wrap, m_term, m_wait;
  logic                              cur_before;
  logic                              due_nxt;
  logic [wts_pkg::WAIT_W-1:0]        term_sec, wait_sec;

  assign target_nxt = wts_pkg::minute_of_day(cfg.photo_hour, cfg.photo_minute);

  always_comb begin
    diff       = $signed({2'b0, target1_r}) - $signed({2'b0, cur1_r});
    wrap       = wts_pkg::MINUTES_PER_DAY + diff;
    cur_before = (cur1_r < target1_r);
    m_term     = cur_before ? diff : wrap;
    m_wait     = (!taken1_r && (cur1_r <= target1_r)) ? diff : wrap;
    due_nxt    = trusted1_r & !taken1_r & !cur_before &
                 ({1'b0, cur1_r} < win_end1_r);
  end

  assign term_sec = wts_pkg::minutes_to_seconds(m_term2_r);
  assign wait_sec = wts_pkg::minutes_to_seconds(m_wait2_r);

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      trusted1_r <= clock_trusted;
      taken1_r   <= (local_year == photo_year) && (local_day_of_year == photo_day);
      cur1_r     <= wts_pkg::minute_of_day(local_hour, local_minute);
      target1_r  <= target_nxt;
      win_end1_r <= {1'b0, target_nxt} + {1'b0, cfg.photo_window_minutes};
    end
    if (adv.s2) begin
      trusted2_r <= trusted1_r;
      due2_r     <= due_nxt;
      m_term2_r  <= m_term[wts_pkg::MDIFF_W-1] ? '0 : m_term[wts_pkg::MWAIT_W-1:0];
      m_wait2_r  <= m_wait[wts_pkg::MDIFF_W-1] ? '0 : m_wait[wts_pkg::MWAIT_W-1:0];
    end
    if (adv.s3) begin
      trusted3_r <= trusted2_r;
      due3_r     <= due2_r;
      term3_r    <= term_sec[wts_pkg::SLEEP_W-1:0];
      if (!trusted2_r) begin
        wait3_r <= '0;
      end else if (wait_sec > wts_pkg::PHOTO_WAIT_CAP) begin
        wait3_r <= wts_pkg::PHOTO_WAIT_CAP;
      end else begin
        wait3_r <= wait_sec;
      end
    end
  end

  assign trusted    = trusted3_r;
  assign photo_due  = due3_r;
  assign photo_term = term3_r;
  assign photo_wait = wait3_r;

endmodule

>>> hw/rtl/wake_task_scheduler.sv
// ----------------------------------------------------------------------------
// wake_task_scheduler
// decides due sensor reads, the daily photo and the next sleep length
// ----------------------------------------------------------------------------
// in_ch takes one request word: current time, last read times of three
// sensors, local clock and date, and the date of the last photo.
// out_ch gives one result word per request: due flags, photo due, sleep
// seconds, photo wait seconds and the unknown flag for an untrusted clock.
// cfg_ch writes the schedule registers, index 0 to 6; other indexes are
// dropped. cfg_ch is always ready; write only while no request is in flight.
// four register stages: config decode, deadline add, remaining time and
// minutes to seconds, then the sleep minimum and the output register.
// an accepted word passes the stage registers in order to out_ch.valid; one word per cycle
// is taken as long as out_ch keeps up.
// when out_ch stalls the stages fill up one by one and in_ch.ready drops
// only once all four hold a word; nothing is dropped or repeated.
// reset (rst_n low, synchronous) empties the pipeline and loads the
// register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wake_task_scheduler #(
  parameter int unsigned MAX_SLEEP_SECONDS = wts_pkg::DEF_MAX_SLEEP_SECONDS,
  parameter int unsigned MIN_WAKE_SECONDS  = wts_pkg::DEF_MIN_WAKE_SECONDS
) (
  input  logic     clk,
  input  logic     rst_n,
  wts_in_if.sink   in_ch,
  wts_out_if.source out_ch,
  wts_cfg_if.sink  cfg_ch
);

  localparam logic [wts_pkg::SLEEP_W-1:0] MAX_SLEEP = wts_pkg::SLEEP_W'(MAX_SLEEP_SECONDS);
  localparam logic [wts_pkg::SLEEP_W-1:0] MIN_WAKE  = wts_pkg::SLEEP_W'(MIN_WAKE_SECONDS);

  wts_pkg::wts_cfg_t                          cfg;
  wts_pkg::wts_adv_t                          adv;
  logic                                       v1_r, v2_r, v3_r, v4_r;
  logic                                       rdy1, rdy2, rdy3, rdy4;

  logic [wts_pkg::NSENS-1:0][wts_pkg::TIME_W-1:0]  last_read;
  logic [wts_pkg::NSENS-1:0]                       lane_due;
  logic [wts_pkg::NSENS-1:0][wts_pkg::SLEEP_W-1:0] lane_rem;

  logic                                       trusted;
  logic                                       photo_due;
  logic [wts_pkg::SLEEP_W-1:0]                photo_term;
  logic [wts_pkg::WAIT_W-1:0]                 photo_wait;

  logic [wts_pkg::SLEEP_W-1:0]                min_a, min_b, photo_cand, sleep_min, sleep_nxt;

  logic [wts_pkg::NSENS-1:0]                  due4_r;
  logic                                       photo_due4_r;
  logic [wts_pkg::SLEEP_W-1:0]                sleep4_r;
  logic [wts_pkg::WAIT_W-1:0]                 wait4_r;
  logic                                       unknown4_r;

  wts_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // stage flow control
  assign rdy4   = out_ch.ready | !v4_r;
  assign rdy3   = rdy4 | !v3_r;
  assign rdy2   = rdy3 | !v2_r;
  assign rdy1   = rdy2 | !v1_r;
  assign adv.s1 = in_ch.valid & rdy1;
  assign adv.s2 = v1_r & rdy2;
  assign adv.s3 = v2_r & rdy3;
  assign adv.s4 = v3_r & rdy4;

  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_ch.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  assign last_read[0] = in_ch.last_read_0;
  assign last_read[1] = in_ch.last_read_1;
  assign last_read[2] = in_ch.last_read_2;

  for (genvar i = 0; i < wts_pkg::NSENS; i++) begin : g_lane
    wts_sensor_lane #(
      .MAX_SLEEP_SECONDS (MAX_SLEEP_SECONDS)
    ) u_lane (
      .clk              (clk),
      .adv              (adv),
      .now_seconds      (in_ch.now_seconds),
      .last_read        (last_read[i]),
      .enable           (cfg.enable_mask[i]),
      .interval_minutes (cfg.interval_minutes[i]),
      .due              (lane_due[i]),
      .remaining        (lane_rem[i])
    );
  end

  wts_photo_calc u_photo (
    .clk               (clk),
    .adv               (adv),
    .cfg               (cfg),
    .clock_trusted     (in_ch.clock_trusted),
    .local_hour        (in_ch.local_hour),
    .local_minute      (in_ch.local_minute),
    .local_year        (in_ch.local_year),
    .local_day_of_year (in_ch.local_day_of_year),
    .photo_year        (in_ch.photo_year),
    .photo_day         (in_ch.photo_day),
    .trusted           (trusted),
    .photo_due         (photo_due),
    .photo_term        (photo_term),
    .photo_wait        (photo_wait)
  );

  // sleep: least of cap, sensor terms and photo term (cap when untrusted), then the floor
  always_comb begin
    photo_cand = trusted ? photo_term : MAX_SLEEP;
    min_a      = (lane_rem[0] < lane_rem[1]) ? lane_rem[0] : lane_rem[1];
    min_b      = (lane_rem[2] < photo_cand) ? lane_rem[2] : photo_cand;
    sleep_min  = (min_a < min_b) ? min_a : min_b;
    if (sleep_min > MAX_SLEEP) begin
      sleep_min = MAX_SLEEP;
    end
    sleep_nxt  = (sleep_min < MIN_WAKE) ? MIN_WAKE : sleep_min;
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      due4_r       <= lane_due;
      photo_due4_r <= photo_due;
      sleep4_r     <= sleep_nxt;
      wait4_r      <= photo_wait;
      unknown4_r   <= !trusted;
    end
  end

  assign out_ch.valid              = v4_r;
  assign out_ch.due_sensor_0       = due4_r[0];
  assign out_ch.due_sensor_1       = due4_r[1];
  assign out_ch.due_sensor_2       = due4_r[2];
  assign out_ch.photo_due          = photo_due4_r;
  assign out_ch.sleep_seconds      = sleep4_r;
  assign out_ch.photo_wait_seconds = wait4_r;
  assign out_ch.photo_wait_unknown = unknown4_r;

  `WTS_ASSERT_IMPL(a_sleep_bounds, clk, rst_n, out_ch.valid,
    (out_ch.sleep_seconds >= MIN_WAKE) &&
    ((out_ch.sleep_seconds <= MAX_SLEEP) || (out_ch.sleep_seconds == MIN_WAKE)))
  `WTS_ASSERT_IMPL(a_untrusted_quiet, clk, rst_n, out_ch.valid && out_ch.photo_wait_unknown,
    (out_ch.photo_wait_seconds == '0) && !out_ch.photo_due)
  `WTS_ASSERT_IMPL(a_due_enabled, clk, rst_n, out_ch.valid,
    ((due4_r & ~cfg.enable_mask) == '0) &&
    (out_ch.photo_wait_seconds <= wts_pkg::PHOTO_WAIT_CAP))
  `WTS_ASSERT_NEXT(a_load_shows, clk, rst_n, adv.s4, out_ch.valid)

endmodule

>>> tb/sv/tb_wake_task_scheduler.sv
// ----------------------------------------------------------------------------
// tb_wake_task_scheduler
// self-checking bench for the wake task scheduler: directed corner words,
// register extremes, random schedules and a long output stall, each result
// word checked in order against a local prediction of the schedule
// ----------------------------------------------------------------------------
module tb_wake_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import wts_pkg::*;

  localparam int unsigned SLEEP_CAP      = DEF_MAX_SLEEP_SECONDS;
  localparam int unsigned SLEEP_FLOOR    = DEF_MIN_WAKE_SECONDS;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 64;
  localparam int unsigned DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [TIME_W-1:0]   now_seconds;
    logic [TIME_W-1:0]   last_read_0;
    logic [TIME_W-1:0]   last_read_1;
    logic [TIME_W-1:0]   last_read_2;
    logic                clock_trusted;
    logic [HOUR_W-1:0]   local_hour;
    logic [MINUTE_W-1:0] local_minute;
    logic [YEAR_W-1:0]   local_year;
    logic [DAY_W-1:0]    local_day_of_year;
    logic [YEAR_W-1:0]   photo_year;
    logic [DAY_W-1:0]    photo_day;
  } sched_req_t;

  typedef struct packed {
    logic               due_sensor_0;
    logic               due_sensor_1;
    logic               due_sensor_2;
    logic               photo_due;
    logic [SLEEP_W-1:0] sleep_seconds;
    logic [WAIT_W-1:0]  photo_wait_seconds;
    logic               photo_wait_unknown;
  } sched_res_t;

  logic clk;
  logic rst_n;

  wts_in_if  in_ch();
  wts_out_if out_ch();
  wts_cfg_if cfg_ch();

  wake_task_scheduler DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [NSENS-1:0]    cfg_mask;
  logic [IVL_W-1:0]    cfg_ivl [NSENS];
  logic [HOUR_W-1:0]   cfg_hour;
  logic [MINUTE_W-1:0] cfg_minute;
  logic [WIN_W-1:0]    cfg_window;

  sched_res_t  expected_results[$];
  int          err_count;
  int unsigned stall_cycles;
  bit          idle_on;
  bit          hold_request;
  bit          hold_active;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic sched_res_t predict_schedule(sched_req_t r);
    longint     now_s, last_s, ivl_s, rem, sleep_s, cur, tgt, win_end, m, wait_s;
    logic [TIME_W-1:0] lr [NSENS];
    logic [NSENS-1:0]  due;
    bit         taken, pdue;
    int         i;
    sched_res_t res;
    lr[0] = r.last_read_0;
    lr[1] = r.last_read_1;
    lr[2] = r.last_read_2;
    now_s = r.now_seconds;
    sleep_s = SLEEP_CAP;
    due = '0;
    for (i = 0; i < NSENS; i++) begin
      last_s = lr[i];
      ivl_s = longint'(cfg_ivl[i]) * 60;
      due[i] = cfg_mask[i] && ((last_s == 0) || (now_s - last_s >= ivl_s));
      if (cfg_mask[i]) begin
        rem = (last_s == 0) ? 0 : last_s + ivl_s - now_s;
        if (rem < 0) rem = 0;
        if (rem < sleep_s) sleep_s = rem;
      end
    end
    taken = (r.local_year == r.photo_year) && (r.local_day_of_year == r.photo_day);
    pdue = 1'b0;
    wait_s = 0;
    if (r.clock_trusted) begin
      cur = longint'(r.local_hour) * 60 + longint'(r.local_minute);
      tgt = longint'(cfg_hour) * 60 + longint'(cfg_minute);
      win_end = tgt + longint'(cfg_window);
      pdue = !taken && cur >= tgt && cur < win_end;
      m = (cur < tgt) ? (tgt - cur) : (1440 - cur + tgt);
      if (m < 0) m = 0;
      if (m * 60 < sleep_s) sleep_s = m * 60;
      if (!taken && cur <= tgt) m = tgt - cur;
      else m = 1440 - cur + tgt;
      if (m < 0) m = 0;
      wait_s = m * 60;
      if (wait_s > longint'(PHOTO_WAIT_CAP)) wait_s = PHOTO_WAIT_CAP;
    end
    if (sleep_s < SLEEP_FLOOR) sleep_s = SLEEP_FLOOR;
    res.due_sensor_0       = due[0];
    res.due_sensor_1       = due[1];
    res.due_sensor_2       = due[2];
    res.photo_due          = pdue;
    res.sleep_seconds      = sleep_s[SLEEP_W-1:0];
    res.photo_wait_seconds = wait_s[WAIT_W-1:0];
    res.photo_wait_unknown = !r.clock_trusted;
    return res;
  endfunction

  function automatic logic [TIME_W-1:0] rnd40();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  function automatic sched_req_t base_request();
    sched_req_t r;
    r.now_seconds       = 40'd1_700_000_000;
    r.last_read_0       = r.now_seconds - 40'd100;
    r.last_read_1       = r.now_seconds - 40'd200;
    r.last_read_2       = r.now_seconds - 40'd300;
    r.clock_trusted     = 1'b1;
    r.local_hour        = 5'd8;
    r.local_minute      = 6'd0;
    r.local_year        = 12'd2024;
    r.local_day_of_year = 9'd100;
    r.photo_year        = 12'd2024;
    r.photo_day         = 9'd99;
    return r;
  endfunction

  function automatic sched_req_t random_request();
    sched_req_t r;
    logic [TIME_W-1:0] lr [NSENS];
    longint ivl_s;
    int     mod, tgt, win, i;
    case ($urandom_range(0, 7))
      0: r.now_seconds = rnd40();
      1: r.now_seconds = TIME_W'($urandom_range(0, 5000));
      default: r.now_seconds = TIME_W'($urandom_range(32'h6000_0000, 32'hFFFF_FFF0));
    endcase
    for (i = 0; i < NSENS; i++) begin
      ivl_s = longint'(cfg_ivl[i]) * 60;
      case ($urandom_range(0, 9))
        0: lr[i] = '0;
        1, 2: lr[i] = r.now_seconds - TIME_W'(ivl_s) + TIME_W'($urandom_range(0, 6))
                      - TIME_W'(3);
        3, 4: lr[i] = r.now_seconds - TIME_W'($urandom_range(0, 32'(2 * ivl_s + 10)));
        5: lr[i] = r.now_seconds + TIME_W'($urandom_range(1, 100000));
        6: lr[i] = r.now_seconds;
        7: lr[i] = rnd40();
        default: lr[i] = r.now_seconds - TIME_W'($urandom_range(0, 3600));
      endcase
    end
    r.last_read_0 = lr[0];
    r.last_read_1 = lr[1];
    r.last_read_2 = lr[2];
    r.clock_trusted = ($urandom_range(0, 3) != 0);
    tgt = int'(cfg_hour) * 60 + int'(cfg_minute);
    win = int'(cfg_window);
    case ($urandom_range(0, 7))
      0: begin
        r.local_hour   = HOUR_W'($urandom());
        r.local_minute = MINUTE_W'($urandom());
      end
      1, 2, 3: begin
        mod = tgt - 2 + int'($urandom_range(0, win + 4));
        if (mod < 0) mod = 0;
        if (mod > 1439) mod = 1439;
        r.local_hour   = HOUR_W'(mod / 60);
        r.local_minute = MINUTE_W'(mod % 60);
      end
      default: begin
        r.local_hour   = HOUR_W'($urandom_range(0, 23));
        r.local_minute = MINUTE_W'($urandom_range(0, 59));
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      r.local_year        = YEAR_W'($urandom());
      r.local_day_of_year = DAY_W'($urandom());
    end else begin
      r.local_year        = YEAR_W'($urandom_range(2000, 2100));
      r.local_day_of_year = DAY_W'($urandom_range(0, 365));
    end
    case ($urandom_range(0, 5))
      0, 1: begin
        r.photo_year = r.local_year;
        r.photo_day  = r.local_day_of_year;
      end
      2: begin
        r.photo_year = r.local_year;
        r.photo_day  = DAY_W'($urandom_range(0, 365));
      end
      3: begin
        r.photo_year = r.local_year - 12'd1;
        r.photo_day  = r.local_day_of_year;
      end
      4: begin
        r.photo_year = YEAR_W'($urandom());
        r.photo_day  = DAY_W'($urandom());
      end
      default: begin
        r.photo_year = r.local_year;
        r.photo_day  = r.local_day_of_year + 9'd1;
      end
    endcase
    return r;
  endfunction

  // called right after a falling edge, returns right after one
  task automatic send_request(input sched_req_t r, input bit allow_gap);
    int gap;
    if (allow_gap && idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_ch.now_seconds       = r.now_seconds;
    in_ch.last_read_0       = r.last_read_0;
    in_ch.last_read_1       = r.last_read_1;
    in_ch.last_read_2       = r.last_read_2;
    in_ch.clock_trusted     = r.clock_trusted;
    in_ch.local_hour        = r.local_hour;
    in_ch.local_minute      = r.local_minute;
    in_ch.local_year        = r.local_year;
    in_ch.local_day_of_year = r.local_day_of_year;
    in_ch.photo_year        = r.photo_year;
    in_ch.photo_day         = r.photo_day;
    in_ch.valid             = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_schedule(r));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ENABLE_MASK:  cfg_mask   = data[NSENS-1:0];
      REG_INTERVAL_0:   cfg_ivl[0] = data[IVL_W-1:0];
      REG_INTERVAL_1:   cfg_ivl[1] = data[IVL_W-1:0];
      REG_INTERVAL_2:   cfg_ivl[2] = data[IVL_W-1:0];
      REG_PHOTO_HOUR:   cfg_hour   = data[HOUR_W-1:0];
      REG_PHOTO_MINUTE: cfg_minute = data[MINUTE_W-1:0];
      REG_PHOTO_WINDOW: cfg_window = data[WIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // no word in flight before a register write
  task automatic settle();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] mask, i0, i1, i2, hour, minute, window);
    settle();
    write_reg(REG_ENABLE_MASK, mask);
    write_reg(REG_INTERVAL_0, i0);
    write_reg(REG_INTERVAL_1, i1);
    write_reg(REG_INTERVAL_2, i2);
    write_reg(REG_PHOTO_HOUR, hour);
    write_reg(REG_PHOTO_MINUTE, minute);
    write_reg(REG_PHOTO_WINDOW, window);
  endtask

  task automatic test_directed_defaults();
    sched_req_t r;
    r = base_request();
    r.last_read_0 = '0;
    r.last_read_1 = '0;
    r.last_read_2 = '0;
    r.local_hour = 5'd12;
    send_request(r, 1'b1);
    // read deadlines exactly met, one second short, one second past
    r = base_request();
    r.last_read_0 = r.now_seconds - 40'd900;
    r.last_read_1 = r.now_seconds - 40'd899;
    r.last_read_2 = r.now_seconds - 40'd901;
    send_request(r, 1'b1);
    // reads in the future
    r = base_request();
    r.last_read_0 = r.now_seconds + 40'd1000;
    r.last_read_1 = r.now_seconds + 40'd1;
    send_request(r, 1'b1);
    r = base_request();
    r.now_seconds = '1;
    r.last_read_0 = '1;
    r.last_read_1 = '1;
    r.last_read_2 = '1;
    send_request(r, 1'b1);
    r = base_request();
    r.now_seconds = '0;
    r.last_read_0 = 40'd1;
    r.last_read_1 = '1;
    send_request(r, 1'b1);
    // untrusted clock at the target
    r = base_request();
    r.clock_trusted = 1'b0;
    r.local_hour = 5'd12;
    send_request(r, 1'b1);
    // photo already taken today
    r = base_request();
    r.photo_day = r.local_day_of_year;
    r.local_hour = 5'd12;
    send_request(r, 1'b1);
    r = base_request();
    r.local_hour = 5'd11;
    r.local_minute = 6'd59;
    send_request(r, 1'b1);
    r.local_hour = 5'd12;
    r.local_minute = 6'd29;
    send_request(r, 1'b1);
    r.local_minute = 6'd30;
    send_request(r, 1'b1);
    r.local_hour = 5'd23;
    r.local_minute = 6'd59;
    send_request(r, 1'b1);
    r.photo_day = r.local_day_of_year;
    send_request(r, 1'b1);
    r = base_request();
    r.local_hour = 5'd0;
    r.local_minute = 6'd0;
    send_request(r, 1'b1);
    // hour and minute beyond their range
    r.local_hour = '1;
    r.local_minute = '1;
    send_request(r, 1'b1);
    r = base_request();
    r.local_hour = 5'd12;
    r.local_minute = 6'd10;
    r.local_year = '1;
    r.local_day_of_year = '1;
    r.photo_year = '1;
    r.photo_day = '1;
    send_request(r, 1'b1);
    r.photo_year = '0;
    r.photo_day = '0;
    send_request(r, 1'b1);
  endtask

  task automatic test_low_registers();
    sched_req_t r;
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    // current minute past the day length, photo term goes negative
    r = base_request();
    r.local_hour = '1;
    r.local_minute = '1;
    send_request(r, 1'b1);
    r.local_hour = '0;
    r.local_minute = '0;
    send_request(r, 1'b1);
    repeat (50) send_request(random_request(), 1'b1);
  endtask

  task automatic test_high_registers();
    sched_req_t r;
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // photo wait saturates
    r = base_request();
    r.local_hour = '0;
    r.local_minute = '0;
    r.photo_day = r.local_day_of_year;
    send_request(r, 1'b1);
    r.photo_day = 9'd0;
    send_request(r, 1'b1);
    r = base_request();
    r.last_read_0 = r.now_seconds - 40'd3_932_100;
    r.last_read_1 = r.now_seconds - 40'd3_932_099;
    r.last_read_2 = '0;
    r.local_hour = '1;
    r.local_minute = '1;
    send_request(r, 1'b1);
    r.local_hour = 5'd23;
    r.local_minute = 6'd59;
    send_request(r, 1'b1);
    repeat (50) send_request(random_request(), 1'b1);
  endtask

  task automatic test_unused_index();
    settle();
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    write_reg(REG_ENABLE_MASK, 16'd5);
    write_reg(REG_INTERVAL_1, 16'd1);
    repeat (20) send_request(random_request(), 1'b1);
  endtask

  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] ivl_word;
    int i;
    repeat (5) begin
      settle();
      write_reg(REG_ENABLE_MASK, CFG_DATA_W'($urandom_range(0, 7)));
      for (i = 0; i < NSENS; i++) begin
        case ($urandom_range(0, 5))
          0: ivl_word = '0;
          1: ivl_word = CFG_DATA_W'($urandom());
          default: ivl_word = CFG_DATA_W'($urandom_range(1, 60));
        endcase
        write_reg(CFG_IDX_W'(REG_INTERVAL_0 + i), ivl_word);
      end
      write_reg(REG_PHOTO_HOUR, ($urandom_range(0, 7) == 0) ? 16'd31
                                : CFG_DATA_W'($urandom_range(0, 23)));
      write_reg(REG_PHOTO_MINUTE, ($urandom_range(0, 7) == 0) ? 16'd63
                                  : CFG_DATA_W'($urandom_range(0, 59)));
      case ($urandom_range(0, 5))
        0: write_reg(REG_PHOTO_WINDOW, 16'd0);
        1: write_reg(REG_PHOTO_WINDOW, 16'd1440);
        default: write_reg(REG_PHOTO_WINDOW, CFG_DATA_W'($urandom_range(1, 120)));
      endcase
      repeat (100) send_request(random_request(), 1'b1);
    end
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    while (!hold_active) @(negedge clk);
    repeat (30) send_request(random_request(), 1'b0);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (150) send_request(random_request(), 1'b1);
  endtask

  initial begin : result_sink
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_active = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
        hold_active = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        n = $urandom_range(0, 11);
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        n = $urandom_range(0, 7);
        repeat (n) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    sched_res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.due_sensor_0       = out_ch.due_sensor_0;
      got.due_sensor_1       = out_ch.due_sensor_1;
      got.due_sensor_2       = out_ch.due_sensor_2;
      got.photo_due          = out_ch.photo_due;
      got.sleep_seconds      = out_ch.sleep_seconds;
      got.photo_wait_seconds = out_ch.photo_wait_seconds;
      got.photo_wait_unknown = out_ch.photo_wait_unknown;
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("%0t: result word with nothing expected", $time);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) begin
            $display("%0t: mismatch expected due=%b%b%b photo=%b sleep=%0d wait=%0d unk=%b",
                     $time, want.due_sensor_0, want.due_sensor_1, want.due_sensor_2,
                     want.photo_due, want.sleep_seconds, want.photo_wait_seconds,
                     want.photo_wait_unknown);
            $display("%0t:          actual   due=%b%b%b photo=%b sleep=%0d wait=%0d unk=%b",
                     $time, got.due_sensor_0, got.due_sensor_1, got.due_sensor_2,
                     got.photo_due, got.sleep_seconds, got.photo_wait_seconds,
                     got.photo_wait_unknown);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    err_count    = 0;
    stall_cycles = 0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    hold_active  = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.now_seconds       = '0;
    in_ch.last_read_0       = '0;
    in_ch.last_read_1       = '0;
    in_ch.last_read_2       = '0;
    in_ch.clock_trusted     = 1'b0;
    in_ch.local_hour        = '0;
    in_ch.local_minute      = '0;
    in_ch.local_year        = '0;
    in_ch.local_day_of_year = '0;
    in_ch.photo_year        = '0;
    in_ch.photo_day         = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    cfg_mask   = 3'd7;
    cfg_ivl[0] = 16'd15;
    cfg_ivl[1] = 16'd15;
    cfg_ivl[2] = 16'd15;
    cfg_hour   = 5'd12;
    cfg_minute = 6'd0;
    cfg_window = 11'd30;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_defaults();
    test_low_registers();
    test_high_registers();
    test_unused_index();
    test_random_settings();
    test_backpressure();
    test_steady_stream();

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    err_count += expected_results.size();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
